>>> hdl/pbw_pkg.sv
`default_nettype none
package pbw_pkg;

  localparam int NUM_AXES = 3;
  localparam int BOX_BITS = 31;
  localparam int MASK_BITS = 3;
  localparam int CFG_INDEX_BITS = 2;

  localparam int DEF_COORD_WIDTH = 32;
  localparam int DEF_FRAC_BITS = 16;

  // register indexes on the configuration channel
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PERIODIC_MASK = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_BOX_SIZE_X    = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_BOX_SIZE_Y    = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_BOX_SIZE_Z    = 2'd3;

  // command codes
  localparam logic CMD_WRAP      = 1'b0;
  localparam logic CMD_MIN_IMAGE = 1'b1;

  // sequencer controls for the remainder unit
  typedef struct packed {
    logic load;
    logic step;
  } pbw_div_ctl_t;

endpackage
`default_nettype wire

>>> hdl/pbw_div_unit.sv
`default_nettype none
module pbw_div_unit #(
  parameter int COORD_WIDTH = pbw_pkg::DEF_COORD_WIDTH
) (
  input  wire logic                       clk,
  input  wire pbw_pkg::pbw_div_ctl_t      ctl,
  input  wire logic [COORD_WIDTH-1:0]     dvd_in [pbw_pkg::NUM_AXES],
  input  wire logic [pbw_pkg::BOX_BITS-1:0] len   [pbw_pkg::NUM_AXES],
  output logic      [pbw_pkg::BOX_BITS-1:0] rem   [pbw_pkg::NUM_AXES]
);
  import pbw_pkg::*;

  logic [COORD_WIDTH-1:0] dvd_r   [NUM_AXES];
  logic [COORD_WIDTH-1:0] dvd_nxt [NUM_AXES];
  logic [BOX_BITS-1:0]    rem_r   [NUM_AXES];
  logic [BOX_BITS-1:0]    rem_nxt [NUM_AXES];
  logic [BOX_BITS:0]      trial   [NUM_AXES];

  // one restoring remainder step per lane: shift in a bit, subtract if it fits
  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      trial[i]   = {rem_r[i], dvd_r[i][COORD_WIDTH-1]};
      dvd_nxt[i] = {dvd_r[i][COORD_WIDTH-2:0], 1'b0};
      if (trial[i] >= {1'b0, len[i]}) begin
        rem_nxt[i] = BOX_BITS'(trial[i] - {1'b0, len[i]});
      end else begin
        rem_nxt[i] = trial[i][BOX_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_AXES; i++) begin
      if (ctl.load) begin
        dvd_r[i] <= dvd_in[i];
        rem_r[i] <= '0;
      end else if (ctl.step) begin
        dvd_r[i] <= dvd_nxt[i];
        rem_r[i] <= rem_nxt[i];
      end
    end
  end

  assign rem = rem_r;

endmodule
`default_nettype wire

>>> hdl/periodic_boundary_wrap_unit.sv
`default_nettype none
// periodic boundary wrap / minimum image for a three-axis fixed-point vector
// a request passes ST_DIV, ST_FOLD and ST_PICK before the out_valid strobe
// a new request is taken only in ST_IDLE, once the last result is strobed; the work
//   is done by the bit-serial remainder unit, one quotient bit per cycle on all axes
// reset (synchronous, rst_n low): sequencer idle, mask 7, box lengths 1.0
// results are shown for one cycle only; the receiver cannot stall
module periodic_boundary_wrap_unit #(
  parameter int COORD_WIDTH = pbw_pkg::DEF_COORD_WIDTH,
  parameter int FRAC_BITS   = pbw_pkg::DEF_FRAC_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // request channel
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic                                in_command,
  input  wire logic signed [COORD_WIDTH-1:0]       in_coord_x,
  input  wire logic signed [COORD_WIDTH-1:0]       in_coord_y,
  input  wire logic signed [COORD_WIDTH-1:0]       in_coord_z,
  // result channel
  output logic                                     out_valid,
  output logic signed [COORD_WIDTH-1:0]            out_wrapped_x,
  output logic signed [COORD_WIDTH-1:0]            out_wrapped_y,
  output logic signed [COORD_WIDTH-1:0]            out_wrapped_z,
  // configuration write channel
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [pbw_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [pbw_pkg::BOX_BITS-1:0]        cfg_data
);
  import pbw_pkg::*;

  // extended width for the exact 2*d against L compares
  localparam int EW = ((COORD_WIDTH > BOX_BITS) ? COORD_WIDTH : BOX_BITS) + 2;
  localparam int CW = $clog2(COORD_WIDTH);
  localparam logic [BOX_BITS-1:0] BOX_RESET = BOX_BITS'(64'd1 << FRAC_BITS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FOLD,
    ST_PICK
  } state_t;

  state_t                  state_r;
  logic [CW-1:0]           cnt_r;
  logic                    cmd_r;
  logic [COORD_WIDTH-1:0]  coord_r    [NUM_AXES];
  logic [BOX_BITS-1:0]     fold_r     [NUM_AXES];
  logic [COORD_WIDTH-1:0]  out_r      [NUM_AXES];
  logic                    out_valid_r;

  logic [MASK_BITS-1:0]    mask_r;
  logic [BOX_BITS-1:0]     box_r      [NUM_AXES];

  logic [COORD_WIDTH-1:0]  in_coord   [NUM_AXES];
  logic [COORD_WIDTH-1:0]  mag        [NUM_AXES];
  logic [BOX_BITS-1:0]     rem        [NUM_AXES];
  logic [BOX_BITS-1:0]     fold_nxt   [NUM_AXES];
  logic [COORD_WIDTH-1:0]  out_nxt    [NUM_AXES];
  pbw_div_ctl_t            div_ctl;
  logic                    accept;

  assign in_coord[0] = in_coord_x;
  assign in_coord[1] = in_coord_y;
  assign in_coord[2] = in_coord_z;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = !busy;

  // the remainder unit works on magnitudes; the sign is folded in afterwards
  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      mag[i] = in_coord[i][COORD_WIDTH-1] ? COORD_WIDTH'(-in_coord[i]) : in_coord[i];
    end
  end

  assign div_ctl.load = accept;
  assign div_ctl.step = (state_r == ST_DIV);

  pbw_div_unit #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_div (
    .clk    (clk),
    .ctl    (div_ctl),
    .dvd_in (mag),
    .len    (box_r),
    .rem    (rem)
  );

  // floored modulo: a negative value with a nonzero remainder maps to L - rem
  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      if (coord_r[i][COORD_WIDTH-1] && (rem[i] != '0)) begin
        fold_nxt[i] = box_r[i] - rem[i];
      end else begin
        fold_nxt[i] = rem[i];
      end
    end
  end

  // pick the result per axis from the folded remainder
  logic signed [EW-1:0] vx     [NUM_AXES];
  logic signed [EW-1:0] rx     [NUM_AXES];
  logic signed [EW-1:0] lx     [NUM_AXES];
  logic signed [EW-1:0] res    [NUM_AXES];
  logic                 big_pos[NUM_AXES];
  logic                 big_neg[NUM_AXES];
  logic                 enable [NUM_AXES];

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      vx[i] = EW'($signed(coord_r[i]));
      rx[i] = $signed({{(EW-BOX_BITS){1'b0}}, fold_r[i]});
      lx[i] = $signed({{(EW-BOX_BITS){1'b0}}, box_r[i]});
      big_pos[i] = (vx[i] > 0) && ((vx[i] <<< 1) > lx[i]);
      big_neg[i] = (vx[i] < 0) && (((-vx[i]) <<< 1) > lx[i]);
      enable[i]  = mask_r[i] && (box_r[i] != '0);
      if (!enable[i]) begin
        res[i] = vx[i];
      end else if (cmd_r == CMD_WRAP) begin
        res[i] = rx[i];
      end else if (big_pos[i]) begin
        // into (-L/2, L/2]
        res[i] = ((rx[i] <<< 1) > lx[i]) ? (rx[i] - lx[i]) : rx[i];
      end else if (big_neg[i]) begin
        // into [-L/2, L/2)
        res[i] = ((rx[i] <<< 1) >= lx[i]) ? (rx[i] - lx[i]) : rx[i];
      end else begin
        // already within half a box
        res[i] = vx[i];
      end
      out_nxt[i] = res[i][COORD_WIDTH-1:0];
    end
  end

  // sequencer: load, COORD_WIDTH remainder steps, fold, pick and strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            cmd_r   <= in_command;
            coord_r <= in_coord;
            cnt_r   <= CW'(COORD_WIDTH - 1);
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            state_r <= ST_FOLD;
          end
        end
        ST_FOLD: begin
          fold_r  <= fold_nxt;
          state_r <= ST_PICK;
        end
        ST_PICK: begin
          out_r       <= out_nxt;
          out_valid_r <= 1'b1;
          state_r     <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // configuration registers, written only while idle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '1;
      for (int i = 0; i < NUM_AXES; i++) begin
        box_r[i] <= BOX_RESET;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PERIODIC_MASK: mask_r   <= cfg_data[MASK_BITS-1:0];
        CFG_BOX_SIZE_X:    box_r[0] <= cfg_data;
        CFG_BOX_SIZE_Y:    box_r[1] <= cfg_data;
        CFG_BOX_SIZE_Z:    box_r[2] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_wrapped_x = out_r[0];
  assign out_wrapped_y = out_r[1];
  assign out_wrapped_z = out_r[2];

endmodule
`default_nettype wire
